// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

   // Default sizing of the slot store
   localparam int DEPTH_DEF     = 64;
   localparam int WORD_BITS_DEF = 32;

   // Fixed widths of the item fields
   localparam int OP_BITS     = 3;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   // Operation codes carried by an input item
   typedef enum logic [OP_BITS-1:0] {
      OP_NONE      = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_PUSH_TAIL = 3'd2,
      OP_POP_HEAD  = 3'd3,
      OP_POP_TAIL  = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SETTLE,
      S_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic emit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
   } flags_type;

endpackage

// ===== rtl/core/deq_ctrl.sv =====
module deq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  deq_pkg::flags_type flags,
   output deq_pkg::cmd_type   cmd
);

   deq_pkg::state_type state_ff;
   deq_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         deq_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = deq_pkg::S_EXEC;
            end
         end
         deq_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = deq_pkg::S_SETTLE;
         end
         deq_pkg::S_SETTLE: begin
            // wait for the slot reads to follow the new pointers
            state_in = deq_pkg::S_EMIT;
         end
         deq_pkg::S_EMIT: begin
            if (flags.out_free) begin
               cmd.emit = 1'b1;
               state_in = deq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/deq_dpath.sv =====
module deq_dpath #(
   parameter int DEPTH     = deq_pkg::DEPTH_DEF,
   parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  deq_pkg::cmd_type                    cmd,
   output deq_pkg::flags_type                  flags,
   input  logic [deq_pkg::OP_BITS-1:0]         req_op,
   input  logic [deq_pkg::VALUE_BITS-1:0]      req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [deq_pkg::VALUE_BITS-1:0]      rsp_popped,
   output logic [deq_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [deq_pkg::COUNT_BITS-1:0]      rsp_count,
   output logic [deq_pkg::VALUE_BITS-1:0]      rsp_front,
   output logic [deq_pkg::VALUE_BITS-1:0]      rsp_back
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   // Circular slot store
   logic [WORD_BITS-1:0] mem [DEPTH];

   logic [PTR_BITS-1:0]         front_ff, front_in;
   logic [PTR_BITS-1:0]         back_ff, back_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic [deq_pkg::OP_BITS-1:0] op_ff;
   logic [WORD_BITS-1:0]        value_ff;
   logic [WORD_BITS-1:0]        popped_ff, popped_in;
   deq_pkg::status_type         status_ff, status_in;
   logic [WORD_BITS-1:0]        rd_front_ff;
   logic [WORD_BITS-1:0]        rd_back_ff;
   logic                        wr_en;
   logic [PTR_BITS-1:0]         wr_addr;
   logic                        full;
   logic                        empty;
   logic                        rsp_valid_ff;
   logic [deq_pkg::VALUE_BITS-1:0]  rsp_popped_ff;
   logic [deq_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [deq_pkg::COUNT_BITS-1:0]  rsp_count_ff;
   logic [deq_pkg::VALUE_BITS-1:0]  rsp_front_ff;
   logic [deq_pkg::VALUE_BITS-1:0]  rsp_back_ff;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_BITS-1:0] ptr_prev(input logic [PTR_BITS-1:0] p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

   assign full  = (count_ff >= CNT_FULL);
   assign empty = (count_ff == '0);

   // Latch the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= WORD_BITS'(req_value);
      end
   end

   // Execute the operation on pointers, count and store
   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = back_ff;
      if (cmd.exec) begin
         popped_in = '0;
         status_in = deq_pkg::ST_DONE;
         case (op_ff)
            deq_pkg::OP_PUSH_HEAD: begin
               if (full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  front_in = ptr_prev(front_ff);
                  wr_en    = 1'b1;
                  wr_addr  = ptr_prev(front_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::OP_PUSH_TAIL: begin
               if (full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = back_ff;
                  back_in  = ptr_next(back_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::OP_POP_HEAD: begin
               if (empty) begin
                  status_in = deq_pkg::ST_EMPTY;
               end else begin
                  popped_in = rd_front_ff;
                  front_in  = ptr_next(front_ff);
                  count_in  = count_ff - 1'b1;
               end
            end
            deq_pkg::OP_POP_TAIL: begin
               if (empty) begin
                  status_in = deq_pkg::ST_EMPTY;
               end else begin
                  popped_in = rd_back_ff;
                  back_in   = ptr_prev(back_ff);
                  count_in  = count_ff - 1'b1;
               end
            end
            deq_pkg::OP_CLEAR: begin
               front_in = '0;
               back_in  = '0;
               count_in = '0;
            end
            default: begin
               // unknown codes only peek
            end
         endcase
      end
   end

   // Pointer and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // Hold popped word and status until emitted
   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   // Write the store, read head and tail slots
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      rd_front_ff <= mem[front_ff];
      rd_back_ff  <= mem[ptr_prev(back_ff)];
   end

   // Output register
   assign flags.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_popped_ff <= deq_pkg::VALUE_BITS'(popped_ff);
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= deq_pkg::COUNT_BITS'(count_ff);
         rsp_front_ff  <= empty ? '0 : deq_pkg::VALUE_BITS'(rd_front_ff);
         rsp_back_ff   <= empty ? '0 : deq_pkg::VALUE_BITS'(rd_back_ff);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_popped = rsp_popped_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_front  = rsp_front_ff;
   assign rsp_back   = rsp_back_ff;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// An accepted item is latched, executed, then held while the registered head and
// tail reads of the slot store follow the updated pointers; its result is then loaded
// into the output register once free. The next item is taken only after that load.
// A waiting result does not block acceptance of the next item.
// Reset (synchronous, active high) clears pointers, count and handshake state;
// the slot store is not cleared and needs no clearing pass.
module double_ended_queue #(
   parameter int DEPTH     = deq_pkg::DEPTH_DEF,
   parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // push_value[31:0]
   input  logic [2:0]   req_tuser,   // operation[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // popped_value[31:0], entry_count[38:32],
                                     // front_value[70:39], back_value[102:71], zero[103]
   output logic [1:0]   rsp_tuser    // status[1:0]
);

   deq_pkg::cmd_type   cmd;
   deq_pkg::flags_type flags;

   logic [deq_pkg::VALUE_BITS-1:0]  rsp_popped;
   logic [deq_pkg::STATUS_BITS-1:0] rsp_status;
   logic [deq_pkg::COUNT_BITS-1:0]  rsp_count;
   logic [deq_pkg::VALUE_BITS-1:0]  rsp_front;
   logic [deq_pkg::VALUE_BITS-1:0]  rsp_back;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   deq_dpath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_op     (req_tuser),
      .req_value  (req_tdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_popped (rsp_popped),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .rsp_front  (rsp_front),
      .rsp_back   (rsp_back)
   );

   // Pack result fields
   assign rsp_tdata = {1'b0, rsp_back, rsp_front, rsp_count, rsp_popped};
   assign rsp_tuser = rsp_status;

endmodule
